FILE: rtl/s5s_pkg.sv
// ----------------------------------------------------------------------------
// s5s_pkg
// shared types and constants of the _S5_ sleep-type scanner
// ----------------------------------------------------------------------------
package s5s_pkg;

   // aml opcodes and prefixes
   localparam logic [7:0] NAME_OP     = 8'h08;
   localparam logic [7:0] PACKAGE_OP  = 8'h12;
   localparam logic [7:0] BYTE_PREFIX = 8'h0A;
   localparam logic [7:0] WORD_PREFIX = 8'h0B;
   localparam logic [7:0] CONST_MAX   = 8'h3F;

   // characters of the name _S5_
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_S          = 8'h53;
   localparam logic [7:0] CHAR_5          = 8'h35;

   // pkglength lead byte: top two bits give the extra byte count
   localparam int         PKG_LEN_SHIFT = 6;
   localparam logic [1:0] PKG_LEN_MASK  = 2'h3;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 16;
   localparam int LEFT_W  = 2;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_TRUNC    = 2'd2,
      ST_BADENC   = 2'd3
   } status_type;

   typedef enum logic [11:0] {
      PH_SEARCH  = 12'b0000_0000_0001,
      PH_GOT_U   = 12'b0000_0000_0010,
      PH_GOT_S   = 12'b0000_0000_0100,
      PH_GOT_5   = 12'b0000_0000_1000,
      PH_NAME    = 12'b0000_0001_0000,
      PH_LEAD    = 12'b0000_0010_0000,
      PH_EXTRA   = 12'b0000_0100_0000,
      PH_NUMEL   = 12'b0000_1000_0000,
      PH_ELEM    = 12'b0001_0000_0000,
      PH_BYTEVAL = 12'b0010_0000_0000,
      PH_WORDLO  = 12'b0100_0000_0000,
      PH_WORDHI  = 12'b1000_0000_0000
   } phase_type;

   // one table byte held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } item_type;

endpackage

FILE: rtl/s5s_input_reg.sv
// ----------------------------------------------------------------------------
// s5s_input_reg
// input register holding one accepted table byte for the scan core
// ----------------------------------------------------------------------------
module s5s_input_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [s5s_pkg::BYTE_W-1:0]     req_tdata,
   input  logic                           req_tlast,
   input  logic                           advance,
   output s5s_pkg::item_type              item
);
   import s5s_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;
   logic              accept;

   // the register empties whenever the core moves on
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;
   assign item.last  = last_ff;

endmodule

FILE: rtl/s5s_scan_core.sv
// ----------------------------------------------------------------------------
// s5s_scan_core
// match state machine, element decode and result register
// ----------------------------------------------------------------------------
module s5s_scan_core (
   input  logic                           clock,
   input  logic                           reset,
   input  s5s_pkg::item_type              item,
   output logic                           advance,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [s5s_pkg::VALUE_W-1:0]    rsp_tdata,
   output logic [1:0]                     rsp_tuser
);
   import s5s_pkg::*;

   phase_type          phase_ff, phase_in;
   logic               at_start_ff, at_start_in;
   logic               prev_nameop_ff, prev_nameop_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [BYTE_W-1:0]  word_low_ff, word_low_in;
   logic               given_ff, given_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic               fire;
   logic               emit;
   logic [BYTE_W-1:0]  b;
   phase_type          search_next;
   phase_type          step_phase;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = item.valid && advance;
   assign b       = item.data;

   // a name may start at offset zero or right after NameOp
   assign search_next = (b == CHAR_UNDERSCORE && (at_start_ff || prev_nameop_ff))
                        ? PH_GOT_U : PH_SEARCH;

   always_comb begin
      phase_in       = phase_ff;
      at_start_in    = at_start_ff;
      prev_nameop_in = prev_nameop_ff;
      left_in        = left_ff;
      word_low_in    = word_low_ff;
      given_in       = given_ff;
      emit           = 1'b0;
      status_in      = ST_FOUND;
      value_in       = '0;
      step_phase     = phase_ff;

      if (fire && !given_ff) begin
         case (phase_ff)
            PH_GOT_U: begin
               step_phase = (b == CHAR_S) ? PH_GOT_S : search_next;
            end
            PH_GOT_S: begin
               step_phase = (b == CHAR_5) ? PH_GOT_5 : search_next;
            end
            PH_GOT_5: begin
               step_phase = (b == CHAR_UNDERSCORE) ? PH_NAME : search_next;
            end
            PH_NAME: begin
               step_phase = (b == PACKAGE_OP) ? PH_LEAD : search_next;
            end
            PH_LEAD: begin
               left_in    = LEFT_W'(b >> PKG_LEN_SHIFT) & PKG_LEN_MASK;
               step_phase = (left_in != '0) ? PH_EXTRA : PH_NUMEL;
            end
            PH_EXTRA: begin
               left_in = left_ff - LEFT_W'(1);
               if (left_in == '0) begin
                  step_phase = PH_NUMEL;
               end
            end
            PH_NUMEL: begin
               step_phase = PH_ELEM;
            end
            PH_ELEM: begin
               if (b == BYTE_PREFIX) begin
                  step_phase = PH_BYTEVAL;
               end else if (b == WORD_PREFIX) begin
                  step_phase = PH_WORDLO;
               end else if (b <= CONST_MAX) begin
                  emit     = 1'b1;
                  value_in = VALUE_W'(b);
               end else begin
                  emit      = 1'b1;
                  status_in = ST_BADENC;
               end
            end
            PH_BYTEVAL: begin
               emit     = 1'b1;
               value_in = VALUE_W'(b);
            end
            PH_WORDLO: begin
               word_low_in = b;
               step_phase  = PH_WORDHI;
            end
            PH_WORDHI: begin
               emit     = 1'b1;
               value_in = {b, word_low_ff};
            end
            default: begin
               step_phase = search_next;
            end
         endcase

         phase_in = step_phase;
         if (step_phase inside {PH_SEARCH, PH_GOT_U, PH_GOT_S, PH_GOT_5, PH_NAME}) begin
            prev_nameop_in = (b == NAME_OP);
         end
         at_start_in = 1'b0;
         if (emit) begin
            given_in = 1'b1;
         end

         // table ends without a result
         if (item.last && !emit) begin
            emit      = 1'b1;
            value_in  = '0;
            status_in = (step_phase inside {PH_SEARCH, PH_GOT_U, PH_GOT_S, PH_GOT_5,
                                            PH_NAME}) ? ST_NOTFOUND : ST_TRUNC;
         end
      end

      // end of table restores the start-of-table state
      if (fire && item.last) begin
         phase_in       = PH_SEARCH;
         at_start_in    = 1'b1;
         prev_nameop_in = 1'b0;
         left_in        = '0;
         word_low_in    = '0;
         given_in       = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = fire && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SEARCH;
         at_start_ff    <= 1'b1;
         prev_nameop_ff <= 1'b0;
         left_ff        <= '0;
         given_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         at_start_ff    <= at_start_in;
         prev_nameop_ff <= prev_nameop_in;
         left_ff        <= left_in;
         given_ff       <= given_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_low_ff <= word_low_in;
      if (fire && emit) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = status_ff;

endmodule

FILE: rtl/aml_s5_sleep_type_scanner.sv
// ----------------------------------------------------------------------------
// aml_s5_sleep_type_scanner
// streaming scan of an aml table for the first element of the _S5_ package
// ----------------------------------------------------------------------------
// Table bytes enter one per transfer in address order, req_tlast marking the
// final byte. The scanner looks for the name _S5_ right after NameOp (or at
// offset zero), then PackageOp, skips the PkgLength and NumElements bytes and
// decodes the first element (BytePrefix, WordPrefix little-endian, or a
// direct constant up to 0x3F). Each table gives exactly one result transfer:
// found with the value, not found, truncated, or bad element encoding; bytes
// after an early result are consumed silently. One byte is taken every clock
// cycle unless the result side stalls, set by the single state update per
// byte; the deciding byte passes the input register, then the result goes to
// the result register. Back-pressure on the result side stalls the input
// only while the result register is full and not being drained.
// ----------------------------------------------------------------------------
module aml_s5_sleep_type_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] table_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sleep_type
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import s5s_pkg::*;

   item_type item;      // byte waiting in the input register
   logic     advance;   // core is ready to take the held byte this cycle

   s5s_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item       (item)
   );

   // matching, decode and result register
   s5s_scan_core u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
